### rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/poq_pkg.sv
package poq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 16;
    localparam int PRIO_BITS   = 32;
    localparam int COUNT_BITS  = 7;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [PADDR_W-3:0] REG_PRIO_MODE = '0;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_KEEP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action                      action;
        logic [ID_BITS-1:0]           entry_id;
        logic signed [PRIO_BITS-1:0]  entry_priority;
        logic [COUNT_BITS-1:0]        keep_count;
    } t_in_word;

    typedef struct packed {
        t_status                      status;
        logic [ID_BITS-1:0]           head_id;
        logic signed [PRIO_BITS-1:0]  head_priority;
        logic [COUNT_BITS-1:0]        removed_count;
        logic [COUNT_BITS-1:0]        occupancy;
    } t_out_word;

    typedef struct packed {
        logic [ID_BITS-1:0]           entry_id;
        logic signed [PRIO_BITS-1:0]  entry_priority;
    } t_entry;

endpackage

### rtl/poq_ram.sv
module poq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/poq_apb.sv
module poq_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [poq_pkg::PADDR_W-1:0]       paddr,
    input  logic [poq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [poq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic                              o_prio_mode
);

    logic                         r_prio_mode;
    logic [poq_pkg::PADDR_W-3:0]  w_index;
    logic                         w_write;

    assign w_index = paddr[poq_pkg::PADDR_W-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_mode <= 1'b1;
        end else if (w_write && (w_index == poq_pkg::REG_PRIO_MODE)) begin
            r_prio_mode <= pwdata[0];
        end
    end

    assign prdata = (w_index == poq_pkg::REG_PRIO_MODE) ?
                    poq_pkg::APB_DATA_W'(r_prio_mode) : '0;
    assign o_prio_mode = r_prio_mode;

endmodule

### rtl/poq_engine.sv
module poq_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_prio_mode,
    input  logic               i_in_valid,
    input  poq_pkg::t_in_word  i_in_word,
    output logic               o_busy,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output poq_pkg::t_out_word o_res_word
);

    localparam int AW = poq_pkg::ADDR_W;
    localparam int CW = poq_pkg::COUNT_BITS;

    poq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_ridx, n_ridx;
    logic [CW-1:0]   r_widx, n_widx;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    logic            r_ins, n_ins;

    poq_pkg::t_action            r_act, n_act;
    poq_pkg::t_entry             r_new, n_new;
    poq_pkg::t_entry             r_carry, n_carry;
    poq_pkg::t_status            r_status, n_status;
    logic [poq_pkg::ID_BITS-1:0] r_hid, n_hid;
    logic signed [poq_pkg::PRIO_BITS-1:0] r_hprio, n_hprio;
    logic [CW-1:0]               r_removed, n_removed;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    poq_pkg::t_entry              w_wdata;
    logic                         w_re;
    logic [$bits(poq_pkg::t_entry)-1:0] w_rd_raw;
    poq_pkg::t_entry              w_rd;
    poq_pkg::t_entry              w_in_entry;
    logic                         w_need_scan;
    logic                         w_scan_end;
    logic                         w_drop;

    assign w_rd       = poq_pkg::t_entry'(w_rd_raw);
    assign w_in_entry = '{entry_id: i_in_word.entry_id,
                          entry_priority: i_in_word.entry_priority};

    // Ordered insert, pop and remove all walk the stored entries once.
    always_comb begin
        w_need_scan = 1'b0;
        unique case (i_in_word.action)
            poq_pkg::ACT_PUSH:
                w_need_scan = (r_fill != poq_pkg::FULL_COUNT) && i_prio_mode &&
                              (r_fill != '0);
            poq_pkg::ACT_POP:    w_need_scan = (r_fill != '0);
            poq_pkg::ACT_REMOVE: w_need_scan = (r_fill != '0);
            poq_pkg::ACT_KEEP:   w_need_scan = 1'b0;
        endcase
    end

    assign w_scan_end = (r_ridx == r_fill) && !r_pend;

    poq_ram #(
        .WIDTH ($bits(poq_pkg::t_entry)),
        .DEPTH (poq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_en   (w_re),
        .i_rd_addr (r_ridx[AW-1:0]),
        .o_rd_data (w_rd_raw)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            poq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_need_scan ? poq_pkg::S_SCAN : poq_pkg::S_DONE;
                end
            end
            poq_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = poq_pkg::S_DONE;
                end
            end
            poq_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = poq_pkg::S_IDLE;
                end
            end
            default: n_state = poq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_fill    = r_fill;
        n_ridx    = r_ridx;
        n_widx    = r_widx;
        n_pidx    = r_pidx;
        n_pend    = 1'b0;
        n_ins     = r_ins;
        n_act     = r_act;
        n_new     = r_new;
        n_carry   = r_carry;
        n_status  = r_status;
        n_hid     = r_hid;
        n_hprio   = r_hprio;
        n_removed = r_removed;
        w_we      = 1'b0;
        w_waddr   = r_fill[AW-1:0];
        w_wdata   = r_carry;
        w_re      = 1'b0;
        w_drop    = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            poq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_act     = i_in_word.action;
                    n_new     = w_in_entry;
                    n_carry   = w_in_entry;
                    n_ins     = 1'b0;
                    n_ridx    = '0;
                    n_widx    = '0;
                    n_status  = poq_pkg::ST_OK;
                    n_hid     = '0;
                    n_hprio   = '0;
                    n_removed = '0;
                    unique case (i_in_word.action)
                        poq_pkg::ACT_PUSH: begin
                            if (r_fill == poq_pkg::FULL_COUNT) begin
                                n_status = poq_pkg::ST_FULL;
                            end else if (!w_need_scan) begin
                                // Tail append needs no walk.
                                w_we    = 1'b1;
                                w_wdata = w_in_entry;
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        poq_pkg::ACT_POP: begin
                            if (r_fill == '0) begin
                                n_status = poq_pkg::ST_EMPTY;
                            end
                        end
                        poq_pkg::ACT_REMOVE: begin
                        end
                        poq_pkg::ACT_KEEP: begin
                            if (i_in_word.keep_count < r_fill) begin
                                n_removed = r_fill - i_in_word.keep_count;
                                n_fill    = i_in_word.keep_count;
                            end
                        end
                    endcase
                end
            end
            poq_pkg::S_SCAN: begin
                // One read is issued per cycle; its data is handled the cycle
                // after, and every write lands at or below that entry.
                if (r_ridx != r_fill) begin
                    w_re   = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                end
                if (r_pend) begin
                    if (r_act == poq_pkg::ACT_PUSH) begin
                        // The new word rides down the queue as a carry once
                        // its slot is found, displacing each later entry.
                        if (r_ins || ($signed(w_rd.entry_priority) <
                                      $signed(r_new.entry_priority))) begin
                            w_we    = 1'b1;
                            w_waddr = r_pidx;
                            w_wdata = r_carry;
                            n_carry = w_rd;
                            n_ins   = 1'b1;
                        end
                    end else begin
                        if (r_act == poq_pkg::ACT_POP) begin
                            w_drop = (r_pidx == '0);
                        end else begin
                            w_drop = (w_rd.entry_id == r_new.entry_id);
                        end
                        if (r_act == poq_pkg::ACT_POP && r_pidx == '0) begin
                            n_hid   = w_rd.entry_id;
                            n_hprio = w_rd.entry_priority;
                        end
                        if (w_drop) begin
                            if (r_act == poq_pkg::ACT_REMOVE) begin
                                n_removed = r_removed + 1'b1;
                            end
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_widx[AW-1:0];
                            w_wdata = w_rd;
                            n_widx  = r_widx + 1'b1;
                        end
                    end
                end
                if (w_scan_end) begin
                    if (r_act == poq_pkg::ACT_PUSH) begin
                        w_we    = 1'b1;
                        w_waddr = r_fill[AW-1:0];
                        w_wdata = r_carry;
                        n_fill  = r_fill + 1'b1;
                    end else begin
                        n_fill = r_widx;
                    end
                end
            end
            poq_pkg::S_DONE: begin
                o_res_valid = i_res_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= poq_pkg::S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx    <= n_ridx;
        r_widx    <= n_widx;
        r_pidx    <= n_pidx;
        r_ins     <= n_ins;
        r_act     <= n_act;
        r_new     <= n_new;
        r_carry   <= n_carry;
        r_status  <= n_status;
        r_hid     <= n_hid;
        r_hprio   <= n_hprio;
        r_removed <= n_removed;
    end

    assign o_busy     = (r_state != poq_pkg::S_IDLE);
    assign o_res_word = '{status: r_status, head_id: r_hid, head_priority: r_hprio,
                          removed_count: r_removed, occupancy: r_fill};

endmodule

### rtl/priority_ordered_ready_queue.sv
// Keep, tail push, full push, empty pop and empty remove go straight to the done
// state after acceptance; ordered push, pop and remove first walk the entry
// memory at one entry per cycle through its single read port. The input stalls
// until the result word enters the output register, so a new word is never
// taken while the last one is still in flight.
// Reset (synchronous, active low) empties the queue and selects priority mode.
`include "assert_macros.svh"

module priority_ordered_ready_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  poq_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output poq_pkg::t_out_word              o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [poq_pkg::PADDR_W-1:0]     paddr,
    input  logic [poq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [poq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic               w_prio_mode;
    logic               w_busy;
    logic               w_res_ready;
    logic               w_res_valid;
    poq_pkg::t_out_word w_res_word;
    logic               r_out_valid;
    poq_pkg::t_out_word r_out_word;

    poq_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_prio_mode (w_prio_mode)
    );

    poq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prio_mode (w_prio_mode),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_busy      (w_busy),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res_word  (w_res_word)
    );

    // The output register frees up in the same cycle its word is taken.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_IMPLIES(a_occ_bound, i_clk, i_rst_n, o_out_valid,
        o_out_word.occupancy <= poq_pkg::FULL_COUNT)
    `ASSERT_IMPLIES(a_full_occ, i_clk, i_rst_n,
        o_out_valid && (o_out_word.status == poq_pkg::ST_FULL),
        o_out_word.occupancy == poq_pkg::FULL_COUNT)
    `ASSERT_IMPLIES(a_empty_pop, i_clk, i_rst_n,
        o_out_valid && (o_out_word.status == poq_pkg::ST_EMPTY),
        (o_out_word.occupancy == '0) && (o_out_word.head_id == '0))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall)

endmodule
